// ===== src/mts_pkg.sv =====
`default_nettype none

package mts_pkg;

    localparam int WORD_W      = 32;
    localparam int OCC_W       = 7;
    localparam int STACK_DEPTH = 64;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic                     opcode;
        logic signed [WORD_W-1:0] push_value;
    } cmd_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] popped_value;
        logic signed [WORD_W-1:0] current_min;
        logic                     is_empty;
        logic [1:0]               status;
        logic [OCC_W-1:0]         occupancy;
    } result_t;

endpackage

`default_nettype wire

// ===== src/mts_ram.sv =====
`default_nettype none

module mts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   clk,
    input  wire logic                   we,
    input  wire logic [AW-1:0]          waddr,
    input  wire logic [WIDTH-1:0]       wdata,
    input  wire logic [AW-1:0]          raddr,
    output      logic [WIDTH-1:0]       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/min_tracking_stack_core.sv =====
// Push: result in the cycle after accept; a push can be taken every cycle.
// Pop: result in the cycle after accept if it empties the stack or underflows;
//   else it waits in ST_POP on the registered RAM read of the entry below the top;
//   busy is high for a single cycle. Top entry lives in registers, the rest in RAM.
// Reset clears the entry count and control; RAM contents are not cleared.
// The receiver cannot stall: done marks each result for exactly one cycle.
`default_nettype none

module min_tracking_stack_core
    import mts_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output      logic    busy,
    input  wire cmd_t    cmd,
    output      logic    done,
    output      result_t result
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW = 2 * WORD_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_POP  = 2'b10
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic signed [WORD_W-1:0] top_val_reg, top_val_next;
    logic signed [WORD_W-1:0] top_min_reg, top_min_next;
    logic                     done_reg, done_next;
    result_t                  result_reg, result_next;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [AW-1:0]            ram_raddr;
    logic [EW-1:0]            ram_wdata;
    logic [EW-1:0]            ram_rdata;

    logic                     accept;
    logic                     full;
    logic                     empty;
    logic [CW-1:0]            count_m1;
    logic [CW-1:0]            count_m2;
    logic signed [WORD_W-1:0] new_min;

    assign accept   = start && (state_reg == ST_IDLE);
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count_m1 = count_reg - CW'(1);
    assign count_m2 = count_reg - CW'(2);
    assign new_min  = (empty || (cmd.push_value < top_min_reg)) ? cmd.push_value : top_min_reg;

    // the entry below the top spills to RAM on push, refills on pop
    assign ram_we    = accept && (cmd.opcode == OP_PUSH) && !full && !empty;
    assign ram_waddr = count_m1[AW-1:0];
    assign ram_wdata = {top_val_reg, top_min_reg};
    assign ram_raddr = count_m2[AW-1:0];

    mts_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        top_val_next = top_val_reg;
        top_min_next = top_min_reg;
        done_next    = 1'b0;
        result_next  = result_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    result_next.popped_value = '0;
                    result_next.status       = STAT_OK;
                    if (cmd.opcode == OP_PUSH)
                    begin
                        done_next = 1'b1;
                        if (full)
                        begin
                            result_next.status      = STAT_OVERFLOW;
                            result_next.current_min = empty ? '0 : top_min_reg;
                            result_next.is_empty    = empty;
                            result_next.occupancy   = OCC_W'(count_reg);
                        end
                        else
                        begin
                            count_next              = count_reg + CW'(1);
                            top_val_next            = cmd.push_value;
                            top_min_next            = new_min;
                            result_next.current_min = new_min;
                            result_next.is_empty    = 1'b0;
                            result_next.occupancy   = OCC_W'(count_reg + CW'(1));
                        end
                    end
                    else
                    begin
                        if (empty)
                        begin
                            done_next               = 1'b1;
                            result_next.status      = STAT_UNDERFLOW;
                            result_next.current_min = '0;
                            result_next.is_empty    = 1'b1;
                            result_next.occupancy   = '0;
                        end
                        else
                        begin
                            count_next = count_m1;
                            result_next.popped_value = top_val_reg;
                            if (count_m1 == '0)
                            begin
                                done_next               = 1'b1;
                                result_next.current_min = '0;
                                result_next.is_empty    = 1'b1;
                                result_next.occupancy   = '0;
                            end
                            else
                            begin
                                // wait for the new top word from RAM
                                state_next = ST_POP;
                            end
                        end
                    end
                end
            end
            ST_POP:
            begin
                top_val_next            = ram_rdata[EW-1:WORD_W];
                top_min_next            = ram_rdata[WORD_W-1:0];
                done_next               = 1'b1;
                result_next.current_min = ram_rdata[WORD_W-1:0];
                result_next.is_empty    = 1'b0;
                result_next.occupancy   = OCC_W'(count_reg);
                state_next              = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_val_reg <= top_val_next;
        top_min_reg <= top_min_next;
        result_reg  <= result_next;
    end

    assign busy   = (state_reg == ST_POP);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_pop_wait_one: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy && done)
        else $error("pop refill did not finish in one cycle");

    a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.opcode == OP_POP && empty) |=>
            (done && result.status == STAT_UNDERFLOW && result.is_empty))
        else $error("pop on empty stack not flagged");

    a_push_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.opcode == OP_PUSH) |=> (done && !result.is_empty))
        else $error("push word not reported next cycle");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/min_tracking_stack_core_tb.sv =====
module min_tracking_stack_core_tb;
    import mts_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int ITEM_TARGET = 1950;

    typedef struct {
        cmd_t        cmd;
        int unsigned gap_after;
        bit          drain;
    } stack_req_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    cmd_t    cmd = '0;
    logic    done;
    result_t result;

    stack_req_t req_backlog[$];
    result_t    awaited_results[$];

    // shadow copy of the stack
    logic signed [WORD_W-1:0] shadow_val [STACK_DEPTH];
    logic signed [WORD_W-1:0] shadow_min [STACK_DEPTH];
    int unsigned shadow_count;

    int unsigned idle_left;
    int unsigned n_taken;
    int unsigned n_seen;
    int unsigned n_fail = 0;
    int unsigned stall_cycles = 0;
    int unsigned gen_total;
    int unsigned gen_occ;
    logic [WORD_W-1:0] last_pushed;

    min_tracking_stack_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always #2 clk = ~clk;

    function automatic result_t apply_stack_op(cmd_t c);
        result_t r;
        r = '0;
        r.status = STAT_OK;
        if (c.opcode == OP_PUSH) begin
            if (shadow_count >= STACK_DEPTH) begin
                r.status = STAT_OVERFLOW;
            end
            else begin
                shadow_val[shadow_count] = c.push_value;
                // ties keep the older minimum
                if (shadow_count != 0 && !(c.push_value < shadow_min[shadow_count-1]))
                    shadow_min[shadow_count] = shadow_min[shadow_count-1];
                else
                    shadow_min[shadow_count] = c.push_value;
                shadow_count++;
            end
        end
        else if (shadow_count == 0) begin
            r.status = STAT_UNDERFLOW;
        end
        else begin
            shadow_count--;
            r.popped_value = shadow_val[shadow_count];
        end
        r.current_min = (shadow_count == 0) ? '0 : shadow_min[shadow_count-1];
        r.is_empty    = (shadow_count == 0);
        r.occupancy   = shadow_count[OCC_W-1:0];
        return r;
    endfunction

    function automatic int unsigned pick_gap(bit quiet);
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return $urandom;
        if (r < 75)
            return WORD_W'(int'($urandom_range(0, 16)) - 8);
        if (r < 85)
            return r[0] ? {1'b0, {(WORD_W-1){1'b1}}} : {1'b1, {(WORD_W-1){1'b0}}};
        return last_pushed;
    endfunction

    task automatic add_req(logic op, logic [WORD_W-1:0] v, bit quiet, bit drain);
        stack_req_t q;
        q.cmd.opcode     = op;
        q.cmd.push_value = (op == OP_PUSH) ? v : WORD_W'($urandom);
        q.gap_after      = pick_gap(quiet);
        q.drain          = drain;
        req_backlog.push_back(q);
        if (op == OP_PUSH) begin
            last_pushed = v;
            if (gen_occ < STACK_DEPTH)
                gen_occ++;
        end
        else if (gen_occ != 0) begin
            gen_occ--;
        end
        gen_total++;
    endtask

    task automatic check_field(string name, logic signed [WORD_W-1:0] want,
                               logic signed [WORD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    // driver: one word on the bus at a time, held until taken
    always @(posedge clk or negedge rst_n)
    begin
        stack_req_t nxt;
        logic       go;
        cmd_t       c;
        int unsigned idle;
        if (!rst_n) begin
            start        <= 1'b0;
            cmd          <= '0;
            idle_left    <= 0;
            n_taken      = 0;
            n_seen       = 0;
            shadow_count = 0;
        end
        else begin
            go   = start;
            c    = cmd;
            idle = idle_left;
            if (done)
                n_seen++;
            if (start && !busy) begin
                awaited_results.push_back(apply_stack_op(cmd));
                n_taken++;
                go = 1'b0;
            end
            if (!go) begin
                if (idle != 0) begin
                    idle--;
                end
                else if (req_backlog.size() != 0 &&
                         !(req_backlog[0].drain && n_taken != n_seen)) begin
                    nxt  = req_backlog.pop_front();
                    go   = 1'b1;
                    c    = nxt.cmd;
                    idle = nxt.gap_after;
                end
            end
            start     <= go;
            cmd       <= c;
            idle_left <= idle;
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n) begin
            if (done) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result word: %p", result);
                    n_fail++;
                end
                else begin
                    want = awaited_results.pop_front();
                    check_field("popped_value", want.popped_value, result.popped_value);
                    check_field("current_min", want.current_min, result.current_min);
                    check_field("is_empty", want.is_empty, result.is_empty);
                    check_field("status", want.status, result.status);
                    check_field("occupancy", want.occupancy, result.occupancy);
                end
            end
            if (done || (start && !busy))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL min_tracking_stack_core");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned seg;
        int unsigned n;
        int unsigned bias;
        bit          quiet;
        bit          settle;
        bit          first;
        logic        op;
        gen_total   = 0;
        gen_occ     = 0;
        last_pushed = '0;

        // directed: underflow on empty, extremes, tie, drain past empty
        add_req(OP_POP, '0, 0, 0);
        add_req(OP_PUSH, 32'd0, 0, 0);
        add_req(OP_PUSH, {1'b0, {(WORD_W-1){1'b1}}}, 0, 0);
        add_req(OP_PUSH, {1'b1, {(WORD_W-1){1'b0}}}, 0, 0);
        add_req(OP_PUSH, {1'b1, {(WORD_W-1){1'b0}}}, 0, 0);
        add_req(OP_PUSH, {WORD_W{1'b1}}, 0, 0);
        add_req(OP_PUSH, 32'd5, 0, 0);
        for (int k = 0; k < 7; k++)
            add_req(OP_POP, '0, 0, 0);
        add_req(OP_PUSH, 32'd7, 1, 0);
        add_req(OP_PUSH, 32'd7, 1, 0);
        add_req(OP_PUSH, 32'd3, 1, 0);
        add_req(OP_POP, '0, 1, 0);
        add_req(OP_POP, '0, 1, 0);
        add_req(OP_POP, '0, 1, 0);
        add_req(OP_POP, '0, 1, 0);

        // random: fill bursts into overflow, drain bursts into underflow, mixed walks
        first = 1'b1;
        while (gen_total < ITEM_TARGET) begin
            seg    = $urandom_range(0, 9);
            quiet  = ($urandom_range(0, 3) == 0);
            settle = first || ($urandom_range(0, 3) == 0);
            bias   = $urandom_range(30, 70);
            case (seg)
                0, 1:    n = STACK_DEPTH - gen_occ + $urandom_range(0, 3);
                2, 3:    n = gen_occ + $urandom_range(0, 3);
                default: n = $urandom_range(10, 60);
            endcase
            for (int k = 0; k < n; k++) begin
                case (seg)
                    0, 1:    op = OP_PUSH;
                    2, 3:    op = OP_POP;
                    default: op = ($urandom_range(0, 99) < bias) ? OP_PUSH : OP_POP;
                endcase
                add_req(op, pick_word(), quiet, settle && k == 0);
            end
            first = 1'b0;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait (req_backlog.size() == 0 && !start);
        wait (awaited_results.size() == 0);
        repeat (8) @(posedge clk);
        if (n_fail == 0)
            $display("PASS min_tracking_stack_core");
        else
            $display("FAIL min_tracking_stack_core");
        $finish;
    end

endmodule
